/* src/fxalu_pkg.sv */
// Package holding the opcode and operation-class types of the Q24.8 arithmetic unit.
package fxalu_pkg;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_INC = 4'd4, OP_DEC = 4'd5, OP_GT = 4'd6, OP_GE = 4'd7,
        OP_LT = 4'd8, OP_LE = 4'd9, OP_EQ = 4'd10, OP_NE = 4'd11,
        OP_MIN = 4'd12, OP_MAX = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        CL_SIMPLE = 2'd0,
        CL_MUL    = 2'd1,
        CL_DIV    = 2'd2
    } t_class;

endpackage

/* src/fxalu_front.sv */
// Front end: accepts operations, classifies them and computes the results of the simple operations.
module fxalu_front import fxalu_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [3:0]           i_mode,
    input  logic [WORD_BITS-1:0] i_operand_a,
    input  logic [WORD_BITS-1:0] i_operand_b,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_class               o_class,
    output logic [WORD_BITS-1:0] o_a,
    output logic [WORD_BITS-1:0] o_b,
    output logic [WORD_BITS-1:0] o_res,
    output logic                 o_cmp,
    output logic                 o_sat
);
    localparam logic [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic r_valid, n_valid;
    t_class r_class, n_class;
    logic [WORD_BITS-1:0] r_a, r_b, r_res, n_res;
    logic r_cmp, n_cmp, r_sat, n_sat;

    logic signed [WORD_BITS-1:0] sa, sb;
    logic signed [WORD_BITS:0] sum;
    logic gt, lt, eq;
    logic signed [WORD_BITS+FRACTION_BITS-1:0] shl;
    t_op op;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        op = t_op'(i_mode);
        sa = i_operand_a;
        sb = i_operand_b;
        gt = sa > sb;
        lt = sa < sb;
        eq = sa == sb;
        n_res = '0;
        n_cmp = 1'b0;
        n_sat = 1'b0;
        n_class = CL_SIMPLE;
        sum = '0;
        shl = {{FRACTION_BITS{sa[WORD_BITS-1]}}, sa} <<< FRACTION_BITS;
        unique case (op)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                unique case (op)
                    OP_ADD:  sum = {sa[WORD_BITS-1], sa} + {sb[WORD_BITS-1], sb};
                    OP_SUB:  sum = {sa[WORD_BITS-1], sa} - {sb[WORD_BITS-1], sb};
                    OP_INC:  sum = {sa[WORD_BITS-1], sa} + (WORD_BITS+1)'(1);
                    default: sum = {sa[WORD_BITS-1], sa} - (WORD_BITS+1)'(1);
                endcase
                if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
                    n_sat = 1'b1;
                    n_res = sum[WORD_BITS] ? MINV : MAXV;
                end else begin
                    n_res = sum[WORD_BITS-1:0];
                end
            end
            OP_MUL: n_class = CL_MUL;
            OP_DIV: n_class = CL_DIV;
            OP_GT:  n_cmp = gt;
            OP_GE:  n_cmp = !lt;
            OP_LT:  n_cmp = lt;
            OP_LE:  n_cmp = !gt;
            OP_EQ:  n_cmp = eq;
            OP_NE:  n_cmp = !eq;
            OP_MIN: n_res = lt ? i_operand_a : i_operand_b;
            OP_MAX: n_res = gt ? i_operand_a : i_operand_b;
            OP_TOINT: n_res = WORD_BITS'(sa >>> FRACTION_BITS);
            default: begin
                if (shl != {{FRACTION_BITS{shl[WORD_BITS-1]}}, shl[WORD_BITS-1:0]}) begin
                    n_sat = 1'b1;
                    n_res = sa[WORD_BITS-1] ? MINV : MAXV;
                end else begin
                    n_res = shl[WORD_BITS-1:0];
                end
            end
        endcase
        n_valid = r_valid && !i_ready;
        if (i_valid && o_ready) n_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            r_class <= n_class;
            r_a <= i_operand_a;
            r_b <= i_operand_b;
            r_res <= n_res;
            r_cmp <= n_cmp;
            r_sat <= n_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_class = r_class;
    assign o_a = r_a;
    assign o_b = r_b;
    assign o_res = r_res;
    assign o_cmp = r_cmp;
    assign o_sat = r_sat;
endmodule

/* src/fxalu_back.sv */
// Back end: pipelined rounding multiplier, pipelined restoring divider and result register.
module fxalu_back import fxalu_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_class               i_class,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic [WORD_BITS-1:0] i_res,
    input  logic                 i_cmp,
    input  logic                 i_sat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_BITS-1:0] o_result_value,
    output logic                 o_compare_true,
    output logic                 o_divide_by_zero,
    output logic                 o_saturated
);
    // Quotient magnitude bits: numerator |a|<<F has W+F bits.
    localparam int NB = WORD_BITS + FRACTION_BITS;
    localparam int HB = WORD_BITS / 2;
    localparam int PW = 2 * WORD_BITS;
    // Stages: 0 operand magnitudes, 1..NB divider steps, NB+1 round and pack.
    localparam int DEPTH = NB + 2;
    localparam logic [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};

    typedef struct packed {
        logic                 valid;
        t_class               cls;
        logic                 neg;
        logic                 dz;
        logic                 cmp;
        logic                 sat;
        logic [WORD_BITS-1:0] res;
        logic [WORD_BITS-1:0] mb;
        logic [NB-1:0]        num;
        logic [NB-1:0]        quo;
        logic [WORD_BITS:0]   rem;
        logic [PW-1:0]        prod;
    } t_stage;

    t_stage r_pipe [DEPTH];
    logic adv;
    logic r_ovalid;
    logic [WORD_BITS-1:0] r_val;
    logic r_cmp, r_dz, r_sat;

    // The whole pipe moves together; it stalls only when the output holds a result.
    assign adv = !r_ovalid || i_ready || !r_pipe[DEPTH-1].valid;
    assign o_ready = adv;

    logic [WORD_BITS-1:0] ma, mb;
    always_comb begin
        ma = i_a[WORD_BITS-1] ? (~i_a + 1'b1) : i_a;
        mb = i_b[WORD_BITS-1] ? (~i_b + 1'b1) : i_b;
    end

    t_stage n_pipe [DEPTH];
    logic [WORD_BITS+1:0] trial;
    logic [WORD_BITS:0] shr;
    logic [PW+1:0] rnd;
    logic [PW-FRACTION_BITS+1:0] mq;
    logic [NB:0] dq;
    logic [WORD_BITS:0] limit;
    logic [NB:0] mag;
    logic over;

    always_comb begin
        n_pipe[0].valid = i_valid;
        n_pipe[0].cls = i_class;
        n_pipe[0].neg = i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
        n_pipe[0].dz = (i_class == CL_DIV) && (i_b == '0);
        n_pipe[0].cmp = i_cmp;
        n_pipe[0].sat = i_sat;
        n_pipe[0].res = i_res;
        n_pipe[0].mb = mb;
        n_pipe[0].num = {ma, {FRACTION_BITS{1'b0}}};
        n_pipe[0].quo = '0;
        n_pipe[0].rem = '0;
        n_pipe[0].prod = {ma, mb};
        for (int s = 1; s < DEPTH - 1; s++) begin
            n_pipe[s] = r_pipe[s-1];
            // one restoring division step per stage
            shr = {r_pipe[s-1].rem[WORD_BITS-1:0], r_pipe[s-1].num[NB-1]};
            trial = {1'b0, shr} - {2'b00, r_pipe[s-1].mb};
            n_pipe[s].num = {r_pipe[s-1].num[NB-2:0], 1'b0};
            if (!trial[WORD_BITS+1]) begin
                n_pipe[s].rem = trial[WORD_BITS:0];
                n_pipe[s].quo = {r_pipe[s-1].quo[NB-2:0], 1'b1};
            end else begin
                n_pipe[s].rem = shr;
                n_pipe[s].quo = {r_pipe[s-1].quo[NB-2:0], 1'b0};
            end
            n_pipe[s].prod = r_pipe[s-1].prod;
        end
        n_pipe[DEPTH-1] = r_pipe[DEPTH-2];
    end

    // Multiplier held in a small side pipe: A*Blo and A*Bhi in parallel, then their sum, then a delay line.
    logic [PW-1:0] r_mlo, r_mhi, r_mprod;
    logic [PW-1:0] r_mdelay [DEPTH-3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mlo <= PW'(r_pipe[0].prod[PW-1:WORD_BITS]) * PW'(r_pipe[0].prod[HB-1:0]);
            r_mhi <= PW'(r_pipe[0].prod[PW-1:WORD_BITS])
                     * PW'(r_pipe[0].prod[WORD_BITS-1:HB]);
            r_mprod <= r_mlo + (r_mhi << HB);
            r_mdelay[0] <= r_mprod;
            for (int k = 1; k < DEPTH - 3; k++) r_mdelay[k] <= r_mdelay[k-1];
        end
    end

    // Output: rounding, clamping and sign for whichever unit the item used.
    t_stage last;
    logic [WORD_BITS-1:0] n_val;
    logic n_sat;
    logic [WORD_BITS+1:0] rem2;
    always_comb begin
        last = r_pipe[DEPTH-1];
        n_val = last.res;
        n_sat = last.sat;
        limit = {1'b0, MAXV} + (WORD_BITS+1)'(last.neg);
        rnd = {2'b00, r_mdelay[DEPTH-4]} + (PW+2)'(1 << (FRACTION_BITS - 1));
        mq = rnd[PW+1:FRACTION_BITS];
        rem2 = {last.rem, 1'b0};
        dq = {1'b0, last.quo} + (NB+1)'(rem2 >= {1'b0, last.mb, 1'b0} - {1'b0, last.mb}
                                         ? 1 : 0);
        mag = '0;
        over = 1'b0;
        unique case (last.cls)
            CL_MUL: begin
                over = mq > (PW-FRACTION_BITS+2)'(limit);
                mag = (NB+1)'(mq[WORD_BITS:0]);
            end
            CL_DIV: begin
                over = dq > (NB+1)'(limit);
                mag = dq;
            end
            default: ;
        endcase
        if (last.cls != CL_SIMPLE) begin
            if (last.dz) begin
                n_val = '0;
                n_sat = 1'b0;
            end else if (over) begin
                n_sat = 1'b1;
                n_val = last.neg ? ~limit[WORD_BITS-1:0] + 1'b1 : limit[WORD_BITS-1:0];
            end else begin
                n_sat = 1'b0;
                n_val = last.neg ? ~mag[WORD_BITS-1:0] + 1'b1 : mag[WORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) r_pipe[s].valid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                for (int s = 0; s < DEPTH; s++) r_pipe[s].valid <= n_pipe[s].valid;
            end
            if (adv && last.valid) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
        if (adv) begin
            for (int s = 0; s < DEPTH; s++) begin
                r_pipe[s].cls <= n_pipe[s].cls;
                r_pipe[s].neg <= n_pipe[s].neg;
                r_pipe[s].dz <= n_pipe[s].dz;
                r_pipe[s].cmp <= n_pipe[s].cmp;
                r_pipe[s].sat <= n_pipe[s].sat;
                r_pipe[s].res <= n_pipe[s].res;
                r_pipe[s].mb <= n_pipe[s].mb;
                r_pipe[s].num <= n_pipe[s].num;
                r_pipe[s].quo <= n_pipe[s].quo;
                r_pipe[s].rem <= n_pipe[s].rem;
                r_pipe[s].prod <= n_pipe[s].prod;
            end
            if (last.valid) begin
                r_val <= n_val;
                r_cmp <= last.cmp;
                r_dz <= last.dz;
                r_sat <= n_sat;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_result_value = r_val;
    assign o_compare_true = r_cmp;
    assign o_divide_by_zero = r_dz;
    assign o_saturated = r_sat;
endmodule

/* src/fixed_point_alu_q24_8.sv */
// Top level of the Q24.8 fixed-point arithmetic unit.
// Every operation passes through the front register, the same back-end pipeline and the
// output register, so results stay in order. Throughput: one transaction per cycle while
// the output does not stall; the divider is one restoring step per stage.
// A result held at the output stalls the whole back end and, through it, the input.
// Reset (synchronous, active low) clears every valid bit; the data registers are not reset.
module fixed_point_alu_q24_8 import fxalu_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [3:0]           i_mode,
    input  logic [WORD_BITS-1:0] i_operand_a,
    input  logic [WORD_BITS-1:0] i_operand_b,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_BITS-1:0] o_result_value,
    output logic                 o_compare_true,
    output logic                 o_divide_by_zero,
    output logic                 o_saturated
);
    // The front register holds one accepted operation ahead of the back-end pipeline.
    logic f_valid, f_ready, f_cmp, f_sat;
    t_class f_class;
    logic [WORD_BITS-1:0] f_a, f_b, f_res;

    fxalu_front #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_class(f_class), .o_a(f_a), .o_b(f_b),
        .o_res(f_res), .o_cmp(f_cmp), .o_sat(f_sat)
    );

    fxalu_back #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready),
        .i_class(f_class), .i_a(f_a), .i_b(f_b),
        .i_res(f_res), .i_cmp(f_cmp), .i_sat(f_sat),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_value(o_result_value), .o_compare_true(o_compare_true),
        .o_divide_by_zero(o_divide_by_zero), .o_saturated(o_saturated)
    );
endmodule

/* tb/tb_fixed_point_alu_q24_8.sv */
// Self-checking testbench for the Q24.8 fixed-point arithmetic unit.
module tb_fixed_point_alu_q24_8;
    import fxalu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 8;
    localparam int RANDOM_ITEMS = 1250;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [31:0] MAXV = 32'h7fffffff;
    localparam logic [31:0] MINV = 32'h80000000;

    typedef struct {
        logic [31:0] value;
        logic        cmp;
        logic        dz;
        logic        sat;
    } alu_result_t;

    // One row of the directed table; has_exp marks rows whose answer is typed in.
    typedef struct {
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
        bit          has_exp;
        alu_result_t exp;
    } directed_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [3:0]  i_mode = '0;
    logic [31:0] i_operand_a = '0;
    logic [31:0] i_operand_b = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result_value;
    logic        o_compare_true;
    logic        o_divide_by_zero;
    logic        o_saturated;

    alu_result_t pending_results[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          stimulus_done = 1'b0;
    bit          quiet_phase = 1'b0;

    fixed_point_alu_q24_8 dut (.*);

    always #5 i_clk = ~i_clk;

    // Clamps an exact wide value to the signed word, raising the saturation flag.
    function automatic logic [31:0] clamp_word(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return MAXV;
        end else if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return MINV;
        end
        return v[31:0];
    endfunction

    // Works out the exact answer of one operation at full precision.
    function automatic alu_result_t alu_expected(input t_op op, input logic [31:0] a_raw,
                                                 input logic [31:0] b_raw);
        alu_result_t r;
        logic signed [127:0] a, b, ma, mb, q, rem, p;
        logic neg;
        r = '{default: 0};
        a = $signed(a_raw);
        b = $signed(b_raw);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        case (op)
            OP_ADD:  r.value = clamp_word(a + b, r.sat);
            OP_SUB:  r.value = clamp_word(a - b, r.sat);
            OP_INC:  r.value = clamp_word(a + 1, r.sat);
            OP_DEC:  r.value = clamp_word(a - 1, r.sat);
            OP_MUL: begin
                // Rounding of the magnitude gives halves away from zero.
                p = (ma * mb + (128'sd1 <<< (FB - 1))) >>> FB;
                r.value = clamp_word(neg ? -p : p, r.sat);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    q = (ma <<< FB) / mb;
                    rem = (ma <<< FB) % mb;
                    if (2 * rem >= mb) q = q + 1;
                    r.value = clamp_word(neg ? -q : q, r.sat);
                end
            end
            OP_GT:   r.cmp = a > b;
            OP_GE:   r.cmp = a >= b;
            OP_LT:   r.cmp = a < b;
            OP_LE:   r.cmp = a <= b;
            OP_EQ:   r.cmp = a == b;
            OP_NE:   r.cmp = a != b;
            OP_MIN:  r.value = (b > a) ? a_raw : b_raw;
            OP_MAX:  r.value = (a > b) ? a_raw : b_raw;
            OP_TOINT: r.value = $signed(a_raw) >>> FB;
            default: r.value = clamp_word(a <<< FB, r.sat);
        endcase
        return r;
    endfunction

    // Picks an operand biased towards the range ends and small values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MAXV - $urandom_range(0, 3);
            1: return MINV + $urandom_range(0, 3);
            2: return $urandom_range(0, 600) - 300;
            3: return 32'($signed($urandom()) >>> $urandom_range(0, 31));
            4: return 32'(0);
            default: return $urandom();
        endcase
    endfunction

    // Sends one transaction and records the expected answer, from the row if it supplies one.
    task automatic send_item(input t_op op, input logic [31:0] a, input logic [31:0] b,
                             input bit has_exp, input alu_result_t exp);
        alu_result_t predicted;
        predicted = alu_expected(op, a, b);
        if (has_exp && predicted != exp) begin
            $display("%0t: table row disagrees with predictor op=%s exp=%h/%b%b%b pred=%h",
                     $time, op.name(), exp.value, exp.cmp, exp.dz, exp.sat, predicted.value);
            error_count++;
        end
        while (!quiet_phase && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        pending_results.push_back(has_exp ? exp : predicted);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Directed rows: extremes, each operation, and each special case.
    directed_row_t directed_rows[] = '{
        '{OP_ADD, MAXV, 32'd1, 1, '{MAXV, 0, 0, 1}},
        '{OP_ADD, MINV, MINV, 1, '{MINV, 0, 0, 1}},
        '{OP_SUB, MINV, 32'd1, 1, '{MINV, 0, 0, 1}},
        '{OP_SUB, MAXV, MINV, 1, '{MAXV, 0, 0, 1}},
        '{OP_MUL, 32'h00000180, 32'h00000080, 0, '{0, 0, 0, 0}},
        '{OP_MUL, 32'hfffffe80, 32'h00000080, 0, '{0, 0, 0, 0}},
        '{OP_MUL, MAXV, MAXV, 1, '{MAXV, 0, 0, 1}},
        '{OP_MUL, MINV, MAXV, 1, '{MINV, 0, 0, 1}},
        '{OP_DIV, 32'h00000100, 32'd0, 1, '{0, 0, 1, 0}},
        '{OP_DIV, MINV, 32'd0, 1, '{0, 0, 1, 0}},
        '{OP_DIV, 32'h00000100, 32'h00000300, 0, '{0, 0, 0, 0}},
        '{OP_DIV, MINV, 32'hffffffff, 1, '{MAXV, 0, 0, 1}},
        '{OP_INC, MAXV, 32'd0, 1, '{MAXV, 0, 0, 1}},
        '{OP_DEC, MINV, 32'd0, 1, '{MINV, 0, 0, 1}},
        '{OP_GT, MAXV, MINV, 1, '{0, 1, 0, 0}},
        '{OP_GE, 32'd5, 32'd5, 1, '{0, 1, 0, 0}},
        '{OP_LT, MAXV, MINV, 1, '{0, 0, 0, 0}},
        '{OP_LE, MINV, MINV, 1, '{0, 1, 0, 0}},
        '{OP_EQ, MINV, MAXV, 1, '{0, 0, 0, 0}},
        '{OP_NE, MINV, MAXV, 1, '{0, 1, 0, 0}},
        '{OP_MIN, 32'hfffffff0, 32'hfffffff0, 1, '{32'hfffffff0, 0, 0, 0}},
        '{OP_MAX, MINV, MAXV, 1, '{MAXV, 0, 0, 0}},
        '{OP_TOINT, 32'hffffff01, 32'd0, 1, '{32'hffffffff, 0, 0, 0}},
        '{OP_FROMINT, 32'h00800000, 32'd0, 1, '{MAXV, 0, 0, 1}},
        '{OP_FROMINT, 32'hff800000, 32'd0, 1, '{MINV, 0, 0, 0}}
    };

    // Stimulus: reset, the directed table, then random transactions.
    initial begin
        int n;
        int quiet_start;
        alu_result_t none;
        none = '{default: 0};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[k])
            send_item(directed_rows[k].op, directed_rows[k].a, directed_rows[k].b,
                      directed_rows[k].has_exp, directed_rows[k].exp);
        quiet_start = $urandom_range(200, 800);
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // A stretch of 200 transactions runs with no idling on either side.
            quiet_phase = (n >= quiet_start) && (n < quiet_start + 200);
            send_item(t_op'($urandom_range(0, 15)), pick_operand(), pick_operand(), 0, none);
        end
        i_valid <= 1'b0;
        quiet_phase = 1'b0;
        stimulus_done = 1'b1;
    end

    // The receiver stalls at random except in the quiet stretch.
    always @(negedge i_clk) begin
        i_ready <= quiet_phase || ($urandom_range(0, 99) >= 25);
    end

    // Result checking against the oldest expectation.
    always @(posedge i_clk) begin
        alu_result_t exp;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%h", $time, o_result_value);
                error_count++;
            end else begin
                exp = pending_results.pop_front();
                if (o_result_value !== exp.value) begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, exp.value, o_result_value);
                    error_count++;
                end
                if (o_compare_true !== exp.cmp) begin
                    $display("%0t: compare_true expected %b actual %b",
                             $time, exp.cmp, o_compare_true);
                    error_count++;
                end
                if (o_divide_by_zero !== exp.dz) begin
                    $display("%0t: divide_by_zero expected %b actual %b",
                             $time, exp.dz, o_divide_by_zero);
                    error_count++;
                end
                if (o_saturated !== exp.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, exp.sat, o_saturated);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no transfer on either side and fails the run at the limit.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // End of run: drain, allow the pipeline latency for stray results, then report.
    initial begin
        wait (stimulus_done && pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
